>>> rtl/core/nibble_length_frame_deframer_defines.svh
// ----------------------------------------------------------------------------
// nibble_length_frame_deframer_defines
// assertion macros shared by the deframer checker
// ----------------------------------------------------------------------------
`ifndef NIBBLE_LENGTH_FRAME_DEFRAMER_DEFINES_SVH
`define NIBBLE_LENGTH_FRAME_DEFRAMER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during rst
`define NLFD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define NLFD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/nlfd_pkg.sv
// ----------------------------------------------------------------------------
// nlfd_pkg
// shared constants, phase encoding and result type of the frame deframer
// ----------------------------------------------------------------------------
package nlfd_pkg;

  // header recognition
  localparam logic [7:0] HDR_MASK = 8'hF0;
  localparam logic [7:0] HDR_MARK = 8'h80;
  localparam logic [7:0] LEN_MASK = 8'h0F;

  // address bytes per frame, 1 to 4
  localparam int ADDR_BYTES = 4;
  localparam int ADDR_CNT_W = (ADDR_BYTES > 1) ? $clog2(ADDR_BYTES) : 1;
  localparam logic [ADDR_CNT_W-1:0] ADDR_CNT_LAST = ADDR_CNT_W'(ADDR_BYTES - 1);

  localparam int ADDR_W = 32;
  localparam int LEN_W  = 4;
  localparam int BYTE_W = 8;

  // deframer phase, one-hot
  typedef enum logic [2:0] {
    PH_HUNT = 3'b001,
    PH_ADDR = 3'b010,
    PH_DATA = 3'b100
  } phase_t;

  // one result request
  typedef struct packed {
    logic [ADDR_W-1:0] frame_address;
    logic [LEN_W-1:0]  payload_length;
    logic [LEN_W-1:0]  byte_index;
    logic [BYTE_W-1:0] payload_byte;
    logic              byte_present;
    logic              frame_last;
  } res_t;

endpackage

>>> rtl/core/nlfd_in_reg.sv
// ----------------------------------------------------------------------------
// nlfd_in_reg
// input register: holds one received byte until the core takes it
// ----------------------------------------------------------------------------
module nlfd_in_reg (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [nlfd_pkg::BYTE_W-1:0] in_byte,
  input  logic                      drain_ok,
  output logic                      take,
  output logic [nlfd_pkg::BYTE_W-1:0] held_byte
);
  import nlfd_pkg::*;

  logic held_valid;

  // core consumes the held byte whenever the result side has room
  assign take     = held_valid & drain_ok;
  assign in_ready = ~held_valid | take;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      held_valid <= 1'b1;
    end else if (take) begin
      held_valid <= 1'b0;
    end
  end

  // byte payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_byte <= in_byte;
    end
  end

endmodule

>>> rtl/core/nlfd_core.sv
// ----------------------------------------------------------------------------
// nlfd_core
// per-byte deframing state machine: header hunt, address gather, payload
// ----------------------------------------------------------------------------
module nlfd_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        take,
  input  logic [nlfd_pkg::BYTE_W-1:0] held_byte,
  output logic                        res_valid,
  output nlfd_pkg::res_t              res
);
  import nlfd_pkg::*;

  phase_t                phase, phase_next;
  logic [ADDR_W-1:0]     address_shift, address_shift_next;
  logic [ADDR_CNT_W-1:0] address_count, address_count_next;
  logic [LEN_W-1:0]      frame_length, frame_length_next;
  logic [LEN_W-1:0]      payload_count, payload_count_next;
  logic                  data_last;

  // last payload byte when index + 1 reaches the length
  assign data_last = ({1'b0, payload_count} + (LEN_W+1)'(1)) >= {1'b0, frame_length};

  // next state and result for the held byte
  always_comb begin
    phase_next         = phase;
    address_shift_next = address_shift;
    address_count_next = address_count;
    frame_length_next  = frame_length;
    payload_count_next = payload_count;
    res_valid          = 1'b0;
    res.frame_address  = address_shift;
    res.payload_length = frame_length;
    res.byte_index     = '0;
    res.payload_byte   = '0;
    res.byte_present   = 1'b0;
    res.frame_last     = 1'b1;
    unique case (phase)
      PH_ADDR: begin
        address_shift_next = {address_shift[ADDR_W-BYTE_W-1:0], held_byte};
        res.frame_address  = address_shift_next;
        if (address_count == ADDR_CNT_LAST) begin
          address_count_next = '0;
          payload_count_next = '0;
          if (frame_length == '0) begin
            // empty frame notice
            phase_next = PH_HUNT;
            res_valid  = 1'b1;
          end else begin
            phase_next = PH_DATA;
          end
        end else begin
          address_count_next = address_count + ADDR_CNT_W'(1);
        end
      end
      PH_DATA: begin
        res_valid          = 1'b1;
        res.byte_index     = payload_count;
        res.payload_byte   = held_byte;
        res.byte_present   = 1'b1;
        res.frame_last     = data_last;
        payload_count_next = payload_count + LEN_W'(1);
        if (data_last) begin
          phase_next         = PH_HUNT;
          payload_count_next = '0;
        end
      end
      default: begin
        // hunting, also any stray code
        phase_next = PH_HUNT;
        if ((held_byte & HDR_MASK) == HDR_MARK) begin
          frame_length_next  = LEN_W'(held_byte & LEN_MASK);
          address_shift_next = '0;
          address_count_next = '0;
          payload_count_next = '0;
          phase_next         = PH_ADDR;
        end
      end
    endcase
  end

  // state registers, advance only on a taken byte
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HUNT;
      address_shift <= '0;
      address_count <= '0;
      frame_length  <= '0;
      payload_count <= '0;
    end else if (take) begin
      phase         <= phase_next;
      address_shift <= address_shift_next;
      address_count <= address_count_next;
      frame_length  <= frame_length_next;
      payload_count <= payload_count_next;
    end
  end

endmodule

>>> rtl/core/nlfd_out_reg.sv
// ----------------------------------------------------------------------------
// nlfd_out_reg
// result register: holds one result request until downstream takes it
// ----------------------------------------------------------------------------
module nlfd_out_reg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          take,
  input  logic                          res_valid,
  input  nlfd_pkg::res_t                res,
  output logic                          drain_ok,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [nlfd_pkg::ADDR_W-1:0]   frame_address,
  output logic [nlfd_pkg::LEN_W-1:0]    payload_length,
  output logic [nlfd_pkg::LEN_W-1:0]    byte_index,
  output logic [nlfd_pkg::BYTE_W-1:0]   payload_byte,
  output logic                          byte_present,
  output logic                          frame_last
);
  import nlfd_pkg::*;

  res_t held;

  // room for a new result when empty or draining this cycle
  assign drain_ok = ~out_valid | out_ready;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= res_valid;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (take && res_valid) begin
      held <= res;
    end
  end

  assign frame_address  = held.frame_address;
  assign payload_length = held.payload_length;
  assign byte_index     = held.byte_index;
  assign payload_byte   = held.payload_byte;
  assign byte_present   = held.byte_present;
  assign frame_last     = held.frame_last;

endmodule

>>> rtl/core/nibble_length_frame_deframer.sv
// ----------------------------------------------------------------------------
// nibble_length_frame_deframer
// byte-stream deframer: 0x8N header, big-endian address, N payload bytes
// ----------------------------------------------------------------------------
// Accepts one byte per clock while in_ready is high. A byte goes through an
// input register and is decoded against the header/address/payload state
// combinationally. Its result (if any) is loaded into the result register
// when the core takes the held byte, which waits while the result register
// is full and not draining; out_valid rises with that load. Each payload
// byte gives one result; a frame with no payload gives one notice with
// byte_present low when its last address byte arrives. Throughput is set by
// the single result register: in_ready depends combinationally on
// out_ready, so a stalled output holds back input once both registers fill.
module nibble_length_frame_deframer (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [nlfd_pkg::BYTE_W-1:0] in_byte,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [nlfd_pkg::ADDR_W-1:0] frame_address,
  output logic [nlfd_pkg::LEN_W-1:0]  payload_length,
  output logic [nlfd_pkg::LEN_W-1:0]  byte_index,
  output logic [nlfd_pkg::BYTE_W-1:0] payload_byte,
  output logic                        byte_present,
  output logic                        frame_last
);
  import nlfd_pkg::*;

  logic              drain_ok;
  logic              take;
  logic [BYTE_W-1:0] held_byte;
  logic              res_valid;
  res_t              res;

  // input register
  nlfd_in_reg u_in_reg (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_byte   (in_byte),
    .drain_ok  (drain_ok),
    .take      (take),
    .held_byte (held_byte)
  );

  // deframing state machine
  nlfd_core u_core (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .held_byte (held_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  // result register
  nlfd_out_reg u_out_reg (
    .clk            (clk),
    .rst            (rst),
    .take           (take),
    .res_valid      (res_valid),
    .res            (res),
    .drain_ok       (drain_ok),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .frame_address  (frame_address),
    .payload_length (payload_length),
    .byte_index     (byte_index),
    .payload_byte   (payload_byte),
    .byte_present   (byte_present),
    .frame_last     (frame_last)
  );

endmodule

>>> rtl/core/nlfd_checker.sv
// ----------------------------------------------------------------------------
// nlfd_checker
// port-level checks on the deframer result stream
// ----------------------------------------------------------------------------
`include "nibble_length_frame_deframer_defines.svh"

module nlfd_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic [7:0]  in_byte,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] frame_address,
  input logic [3:0]  payload_length,
  input logic [3:0]  byte_index,
  input logic [7:0]  payload_byte,
  input logic        byte_present,
  input logic        frame_last
);

  logic [49:0] out_bundle;
  logic        out_stall;
  logic        in_stall;
  logic        notice_ok;
  logic        index_ok;
  logic        last_ok;

  // helper terms
  assign out_bundle = {frame_address, payload_length, byte_index, payload_byte,
                       byte_present, frame_last};
  assign out_stall  = out_valid && !out_ready;
  assign in_stall   = in_valid && !in_ready;
  assign notice_ok  = frame_last && payload_length == 4'd0 && byte_index == 4'd0 &&
                      payload_byte == 8'd0;
  assign index_ok   = payload_length != 4'd0 && byte_index < payload_length;
  assign last_ok    = frame_last == (byte_index == payload_length - 4'd1);

  // empty-frame notice is a lone, last, zeroed request
  `NLFD_ASSERT_NOW(a_notice_shape, out_valid && !byte_present, notice_ok, "bad notice")

  // payload index stays inside the frame length
  `NLFD_ASSERT_NOW(a_index_range, out_valid && byte_present, index_ok, "index out of range")

  // last mark exactly on the final payload byte
  `NLFD_ASSERT_NOW(a_last_mark, out_valid && byte_present, last_ok, "last mark misplaced")

  // stalled result holds
  `NLFD_ASSERT_NXT(a_out_hold, out_stall, out_valid && $stable(out_bundle), "result moved")

  // waiting input request holds
  `NLFD_ASSERT_NXT(a_in_hold, in_stall, in_valid && $stable(in_byte), "request moved")

endmodule

bind nibble_length_frame_deframer nlfd_checker u_nlfd_checker (.*);
